/* rtl/hashed_call_profile_counter_assert.svh */
// Assertion macros for the hashed call profile counter.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef HASHED_CALL_PROFILE_COUNTER_ASSERT_SVH
`define HASHED_CALL_PROFILE_COUNTER_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define HCPC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcpc assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define HCPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcpc assertion failed");
`endif

/* rtl/hcpc_pkg.sv */
// Shared types, constants and helpers of the hashed call profile counter.
// Depends on nothing.
package hcpc_pkg;
  localparam int TABLE_ENTRIES = 4096;
  localparam int ADDR_W = $clog2(TABLE_ENTRIES);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic [2:0] STS_COUNTED = 3'd0;
  localparam logic [2:0] STS_REPEAT = 3'd1;
  localparam logic [2:0] STS_INSERTED = 3'd2;
  localparam logic [2:0] STS_LOST = 3'd3;
  localparam logic [2:0] STS_OTHER = 3'd4;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0] op;
    logic [31:0] key;
    logic [ADDR_W-1:0] home;
    logic [ADDR_W-1:0] idx;
  } hcpc_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [11:0] slot_used;
    logic entry_valid;
    logic [15:0] entry_class;
    logic [15:0] entry_selector;
    logic [31:0] entry_count;
    logic [31:0] samples_total;
    logic [31:0] extra_probes_total;
    logic [31:0] lost_total;
  } hcpc_res_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == SAT32) ? v : v + 32'd1;
  endfunction
endpackage

/* rtl/hashed_call_profile_counter.sv */
// Top level of the hashed call profile counter.
// Depends on hcpc_pkg, hcpc_front, hcpc_queue, hcpc_back and the assertion header.
//
// Usage: record, new-sample, clear and read beats enter on the in_ channel
// (valid/ready) and each gives exactly one result beat on the out_ channel.
// The one register, accumulate_mode, is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle.
// The block itself does not enforce this. A record with a nonzero key
// probes the table from its home slot onward, one slot per ISSUE and CHK
// state pair, until it finds its key or an empty slot or has probed every
// slot of a full table; a read visits its one slot through the same states.
// A clear, and a new sample in accumulate mode, give their result at once
// but then sweep every slot of the table memory before the next beat is
// served; beats still enter the two-entry queue meanwhile.
// After reset the same sweep empties the table, and in_ready stays low
// throughout it (configuration writes are taken).
// When the receiver stalls, the result waits in the output register; the
// queue keeps accepting until full, and then in_ready falls.
module hashed_call_profile_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_class_id,
  input  logic [15:0] in_selector_id,
  input  logic [11:0] in_slot_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [11:0] out_slot_used,
  output logic        out_entry_valid,
  output logic [15:0] out_entry_class,
  output logic [15:0] out_entry_selector,
  output logic [31:0] out_entry_count,
  output logic [31:0] out_samples_total,
  output logic [31:0] out_extra_probes_total,
  output logic [31:0] out_lost_total
);
  `include "hashed_call_profile_counter_assert.svh"

  hcpc_pkg::hcpc_item_t item, q_data;
  hcpc_pkg::hcpc_res_t res;
  logic q_full, q_empty, q_pop, init_busy, push;

  // The front end classifies each beat; the queue decouples it from the
  // back end, which runs the probe walk and the memory sweeps.
  hcpc_front u_front (
    .in_operation   (in_operation),
    .in_class_id    (in_class_id),
    .in_selector_id (in_selector_id),
    .in_slot_index  (in_slot_index),
    .item           (item)
  );

  assign in_ready = !q_full && !init_busy;
  assign push = in_valid && in_ready;

  hcpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (item),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  hcpc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .init_busy   (init_busy),
    .res_valid   (out_valid),
    .res_ready   (out_ready),
    .res         (res)
  );

  assign out_status = res.status;
  assign out_slot_used = res.slot_used;
  assign out_entry_valid = res.entry_valid;
  assign out_entry_class = res.entry_class;
  assign out_entry_selector = res.entry_selector;
  assign out_entry_count = res.entry_count;
  assign out_samples_total = res.samples_total;
  assign out_extra_probes_total = res.extra_probes_total;
  assign out_lost_total = res.lost_total;

  // Nothing enters while the table is being emptied after reset.
  `HCPC_ASSERT_IMPL(a_no_accept_in_init, init_busy, !in_ready)
  // The back end never takes a beat from an empty queue.
  `HCPC_ASSERT_IMPL(a_pop_not_empty, q_pop, !q_empty)
  // A popped beat never overwrites a result that is still waiting.
  `HCPC_ASSERT_IMPL(a_pop_out_free, q_pop, !out_valid)
  // Status codes stay within the defined set.
  `HCPC_ASSERT_NEXT(a_status_range, out_valid && !out_ready, out_status <= hcpc_pkg::STS_OTHER)
endmodule

/* rtl/hcpc_front.sv */
// Front end: forms the key and home slot of each incoming beat.
// Depends on hcpc_pkg.
module hcpc_front (
  input  logic [1:0]           in_operation,
  input  logic [15:0]          in_class_id,
  input  logic [15:0]          in_selector_id,
  input  logic [11:0]          in_slot_index,
  output hcpc_pkg::hcpc_item_t item
);
  logic [20:0] hsum;

  // Home slot is (class << 4) + selector, reduced by the power-of-two size.
  assign hsum = {1'b0, in_class_id, 4'b0000} + {5'b00000, in_selector_id};

  always_comb begin
    item.op = in_operation;
    item.key = {in_class_id, 16'h0000} ^ {16'h0000, in_selector_id};
    item.home = hsum[hcpc_pkg::ADDR_W-1:0];
    item.idx = in_slot_index[hcpc_pkg::ADDR_W-1:0];
  end
endmodule

/* rtl/hcpc_queue.sv */
// Short queue of classified beats between front and back end.
// Depends on hcpc_pkg.
module hcpc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  hcpc_pkg::hcpc_item_t push_data,
  input  logic                 pop,
  output hcpc_pkg::hcpc_item_t pop_data,
  output logic                 full,
  output logic                 empty
);
  hcpc_pkg::hcpc_item_t mem_r [hcpc_pkg::QDEPTH];
  logic [hcpc_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [hcpc_pkg::QPTR_W:0] cnt_r;

  assign full = (cnt_r == (hcpc_pkg::QPTR_W+1)'(hcpc_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (hcpc_pkg::QPTR_W+1)'(push) - (hcpc_pkg::QPTR_W+1)'(pop);
    end
  end
endmodule

/* rtl/hcpc_back.sv */
// Back end: probe sequencer, slot memories, totals and the result register.
// Depends on hcpc_pkg.
module hcpc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 q_empty,
  input  hcpc_pkg::hcpc_item_t q_data,
  output logic                 q_pop,
  output logic                 init_busy,
  output logic                 res_valid,
  input  logic                 res_ready,
  output hcpc_pkg::hcpc_res_t  res
);
  localparam int AW = hcpc_pkg::ADDR_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SWEEP = 4'b0010,
    S_ISSUE = 4'b0100,
    S_CHK   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt, probe_r, probe_nxt;
  logic [31:0] key_r, key_nxt;
  logic is_read_r, is_read_nxt, full_clr_r, full_clr_nxt, init_r, init_nxt;
  logic acc_r, acc_nxt;
  logic [31:0] samples_r, samples_nxt, miss_r, miss_nxt, lost_r, lost_nxt;
  logic valid_r, valid_nxt;
  hcpc_pkg::hcpc_res_t res_r, res_nxt;

  logic [31:0] key_mem [hcpc_pkg::TABLE_ENTRIES];
  logic [31:0] cnt_mem [hcpc_pkg::TABLE_ENTRIES];
  logic seen_mem [hcpc_pkg::TABLE_ENTRIES];
  logic [31:0] key_q, cnt_q;
  logic seen_q;
  logic key_we, cnt_we, seen_we;
  logic [AW-1:0] wr_addr;
  logic [31:0] wr_key, wr_cnt;
  logic wr_seen;

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    key_q <= key_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
    cnt_q <= cnt_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (seen_we) begin
      seen_mem[wr_addr] <= wr_seen;
    end
    seen_q <= seen_mem[addr_r];
  end

  assign init_busy = init_r;
  assign res_valid = valid_r;
  assign res = res_r;

  always_comb begin
    state_nxt = state_r;
    addr_nxt = addr_r;
    probe_nxt = probe_r;
    key_nxt = key_r;
    is_read_nxt = is_read_r;
    full_clr_nxt = full_clr_r;
    init_nxt = init_r;
    acc_nxt = cfg_wr_en ? cfg_wr_data : acc_r;
    samples_nxt = samples_r;
    miss_nxt = miss_r;
    lost_nxt = lost_r;
    valid_nxt = valid_r && !res_ready;
    res_nxt = res_r;
    q_pop = 1'b0;
    key_we = 1'b0;
    cnt_we = 1'b0;
    seen_we = 1'b0;
    wr_addr = addr_r;
    wr_key = '0;
    wr_cnt = '0;
    wr_seen = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        // Work starts only with the result register empty, so the result
        // of this beat always finds room when it completes.
        if (!q_empty && !valid_r) begin
          q_pop = 1'b1;
          res_nxt = '0;
          res_nxt.status = hcpc_pkg::STS_OTHER;
          res_nxt.samples_total = samples_r;
          res_nxt.extra_probes_total = miss_r;
          res_nxt.lost_total = lost_r;
          unique case (q_data.op)
            hcpc_pkg::OP_RECORD: begin
              if (q_data.key == '0) begin
                valid_nxt = 1'b1;
              end else begin
                key_nxt = q_data.key;
                addr_nxt = q_data.home;
                probe_nxt = '0;
                is_read_nxt = 1'b0;
                state_nxt = S_ISSUE;
              end
            end
            hcpc_pkg::OP_SAMPLE: begin
              samples_nxt = hcpc_pkg::sat_inc(samples_r);
              res_nxt.samples_total = samples_nxt;
              valid_nxt = 1'b1;
              if (acc_r) begin
                full_clr_nxt = 1'b0;
                addr_nxt = '0;
                state_nxt = S_SWEEP;
              end
            end
            hcpc_pkg::OP_CLEAR: begin
              samples_nxt = '0;
              miss_nxt = '0;
              lost_nxt = '0;
              res_nxt.samples_total = '0;
              res_nxt.extra_probes_total = '0;
              res_nxt.lost_total = '0;
              valid_nxt = 1'b1;
              full_clr_nxt = 1'b1;
              addr_nxt = '0;
              state_nxt = S_SWEEP;
            end
            default: begin
              addr_nxt = q_data.idx;
              is_read_nxt = 1'b1;
              state_nxt = S_ISSUE;
            end
          endcase
        end
      end
      S_SWEEP: begin
        seen_we = 1'b1;
        key_we = full_clr_r;
        cnt_we = full_clr_r;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(hcpc_pkg::TABLE_ENTRIES - 1)) begin
          init_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_ISSUE: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        res_nxt.slot_used = 12'(addr_r);
        res_nxt.entry_valid = (key_q != '0);
        res_nxt.entry_class = key_q[31:16];
        res_nxt.entry_selector = key_q[15:0];
        res_nxt.entry_count = cnt_q;
        if (is_read_r) begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (key_q == key_r) begin
          if (!acc_r || !seen_q) begin
            wr_cnt = hcpc_pkg::sat_inc(cnt_q);
            cnt_we = 1'b1;
            wr_seen = 1'b1;
            seen_we = 1'b1;
            res_nxt.entry_count = wr_cnt;
            res_nxt.status = hcpc_pkg::STS_COUNTED;
          end else begin
            res_nxt.status = hcpc_pkg::STS_REPEAT;
          end
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (key_q == '0) begin
          wr_key = key_r;
          wr_cnt = 32'd1;
          wr_seen = 1'b1;
          key_we = 1'b1;
          cnt_we = 1'b1;
          seen_we = 1'b1;
          res_nxt.status = hcpc_pkg::STS_INSERTED;
          res_nxt.entry_valid = 1'b1;
          res_nxt.entry_class = key_r[31:16];
          res_nxt.entry_selector = key_r[15:0];
          res_nxt.entry_count = 32'd1;
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          miss_nxt = hcpc_pkg::sat_inc(miss_r);
          res_nxt.extra_probes_total = miss_nxt;
          if (probe_r == AW'(hcpc_pkg::TABLE_ENTRIES - 1)) begin
            lost_nxt = hcpc_pkg::sat_inc(lost_r);
            res_nxt.status = hcpc_pkg::STS_LOST;
            res_nxt.slot_used = '0;
            res_nxt.entry_valid = 1'b0;
            res_nxt.entry_class = '0;
            res_nxt.entry_selector = '0;
            res_nxt.entry_count = '0;
            res_nxt.lost_total = lost_nxt;
            valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            probe_nxt = probe_r + 1'b1;
            addr_nxt = addr_r + 1'b1;
            state_nxt = S_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      addr_r <= '0;
      full_clr_r <= 1'b1;
      init_r <= 1'b1;
      acc_r <= 1'b1;
      samples_r <= '0;
      miss_r <= '0;
      lost_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r <= addr_nxt;
      full_clr_r <= full_clr_nxt;
      init_r <= init_nxt;
      acc_r <= acc_nxt;
      samples_r <= samples_nxt;
      miss_r <= miss_nxt;
      lost_r <= lost_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
    key_r <= key_nxt;
    is_read_r <= is_read_nxt;
    res_r <= res_nxt;
  end
endmodule
